// ===== hw/rtl/rep_pkg.sv =====
`default_nettype none

package rep_pkg;

  // fixed formats of the payload fields
  localparam int COORD_BITS = 24;
  localparam int COEF_BITS  = 16;
  localparam int FRAC_SHIFT = COEF_BITS - 2;

  // datapath widths
  localparam int EZ_W   = COORD_BITS + 1;          // z after reflection
  localparam int PROD_W = COEF_BITS + EZ_W;        // one matrix product
  localparam int SUM_W  = PROD_W + 2;              // sum of three products
  localparam int ROT_W  = SUM_W - FRAC_SHIFT;      // rotated component
  localparam int NUM_W  = ROT_W + COORD_BITS;      // |a| * |pz|
  localparam int MW     = NUM_W + 1;               // 2*n + d
  localparam int DW     = ROT_W + 1;               // 2*d
  localparam int RW     = DW + 1;                  // partial remainder
  localparam int QW     = ROT_W;                   // quotient bits
  localparam int SW     = QW + 2;                  // position plus offset

  // configuration port
  localparam int ROW_W      = 3 * COEF_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0 = 2'd0,
    REG_ROT_ROW1 = 2'd1,
    REG_ROT_ROW2 = 2'd2
  } cfg_reg_t;

  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(1) << FRAC_SHIFT;
  localparam logic [ROW_W-1:0] ROW1_RST = ROW0_RST << COEF_BITS;
  localparam logic [ROW_W-1:0] ROW2_RST = ROW0_RST << (2 * COEF_BITS);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // [row][column]
  typedef logic [2:0][2:0][COEF_BITS-1:0] mat_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t edge_x;
    coord_t edge_y;
    coord_t edge_z;
    logic   reflect;
  } in_t;

  typedef struct packed {
    logic   hit;
    coord_t cross_x;
    coord_t cross_y;
  } out_t;

  typedef struct packed {
    coord_t                        px;
    coord_t                        py;
    logic signed [EZ_W-1:0]        pz;
    logic [2:0][2:0][PROD_W-1:0]   prod;
  } prod_t;

  typedef struct packed {
    coord_t                  px;
    coord_t                  py;
    logic signed [EZ_W-1:0]  pz;
    logic [2:0][ROT_W-1:0]   a;
  } rot_t;

  typedef struct packed {
    coord_t             px;
    coord_t             py;
    logic               hit;
    logic               neg_x;
    logic               neg_y;
    logic [NUM_W-1:0]   nx;
    logic [NUM_W-1:0]   ny;
    logic [ROT_W-1:0]   dz;
  } num_t;

  typedef struct packed {
    coord_t           px;
    coord_t           py;
    logic             hit;
    logic             neg_x;
    logic             neg_y;
    logic [MW-1:0]    mx;
    logic [MW-1:0]    my;
    logic [DW-1:0]    dd;
    logic [RW-1:0]    rx;
    logic [RW-1:0]    ry;
    logic [QW-1:0]    qx;
    logic [QW-1:0]    qy;
  } div_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rep_rotate.sv =====
`default_nettype none

module rep_rotate (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  rep_pkg::in_t   data_i,
  input  rep_pkg::mat_t  mat,
  output logic           valid_o,
  output rep_pkg::rot_t  data_o
);

  localparam logic signed [rep_pkg::SUM_W-1:0] RND =
    rep_pkg::SUM_W'(1) << (rep_pkg::FRAC_SHIFT - 1);

  rep_pkg::prod_t prod_nxt, prod_r;
  logic           prod_v_r;
  rep_pkg::rot_t  rot_nxt, rot_r;
  logic           rot_v_r;

  // stage 1: reflection and the nine products
  always_comb begin
    logic signed [rep_pkg::EZ_W-1:0]      e [3];
    logic signed [rep_pkg::EZ_W-1:0]      pz;
    logic signed [rep_pkg::COEF_BITS-1:0] c;
    logic signed [rep_pkg::PROD_W-1:0]    p;
    e[0] = rep_pkg::EZ_W'(data_i.edge_x);
    e[1] = rep_pkg::EZ_W'(data_i.edge_y);
    e[2] = rep_pkg::EZ_W'(data_i.edge_z);
    pz   = rep_pkg::EZ_W'(data_i.pos_z);
    if (data_i.reflect) begin
      e[2] = -e[2];
      pz   = -pz;
    end
    prod_nxt.px = data_i.pos_x;
    prod_nxt.py = data_i.pos_y;
    prod_nxt.pz = pz;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        c = mat[r][k];
        p = c * e[k];
        prod_nxt.prod[r][k] = p;
      end
    end
  end

  // stage 2: row sums, rounded to the coordinate grid by floor(x + half)
  always_comb begin
    logic signed [rep_pkg::SUM_W-1:0] acc;
    rot_nxt.px = prod_r.px;
    rot_nxt.py = prod_r.py;
    rot_nxt.pz = prod_r.pz;
    for (int r = 0; r < 3; r++) begin
      acc = $signed(prod_r.prod[r][0]) + $signed(prod_r.prod[r][1])
          + $signed(prod_r.prod[r][2]) + RND;
      rot_nxt.a[r] = acc[rep_pkg::SUM_W-1:rep_pkg::FRAC_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      rot_v_r  <= 1'b0;
    end else if (en) begin
      prod_v_r <= valid_i;
      rot_v_r  <= prod_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      rot_r  <= rot_nxt;
    end
  end

  assign valid_o = rot_v_r;
  assign data_o  = rot_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rep_setup.sv =====
`default_nettype none

module rep_setup (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  rep_pkg::rot_t  data_i,
  output logic           valid_o,
  output rep_pkg::div_t  data_o
);

  rep_pkg::num_t num_nxt, num_r;
  logic          num_v_r;
  rep_pkg::div_t div_nxt, div_r;
  logic          div_v_r;

  // stage 3: crossing test, magnitudes and the two numerator products
  always_comb begin
    logic signed [rep_pkg::ROT_W:0]       zsum;
    logic signed [rep_pkg::ROT_W-1:0]     ax, ay, az;
    logic [rep_pkg::ROT_W-1:0]            mag_x, mag_y;
    logic [rep_pkg::COORD_BITS-1:0]       mag_z;
    logic                                 below;
    ax    = data_i.a[0];
    ay    = data_i.a[1];
    az    = data_i.a[2];
    below = data_i.pz[rep_pkg::EZ_W-1];
    zsum  = az + data_i.pz;
    // below the plane must end above it, otherwise it must end below
    if (below) begin
      num_nxt.hit = !zsum[rep_pkg::ROT_W] && (zsum != '0);
    end else begin
      num_nxt.hit = zsum[rep_pkg::ROT_W];
    end
    mag_x = ax[rep_pkg::ROT_W-1] ? rep_pkg::ROT_W'(-ax) : rep_pkg::ROT_W'(ax);
    mag_y = ay[rep_pkg::ROT_W-1] ? rep_pkg::ROT_W'(-ay) : rep_pkg::ROT_W'(ay);
    mag_z = below ? rep_pkg::COORD_BITS'(-data_i.pz)
                  : rep_pkg::COORD_BITS'(data_i.pz);
    num_nxt.px    = data_i.px;
    num_nxt.py    = data_i.py;
    num_nxt.neg_x = ax[rep_pkg::ROT_W-1];
    num_nxt.neg_y = ay[rep_pkg::ROT_W-1];
    num_nxt.nx    = rep_pkg::NUM_W'(mag_x) * rep_pkg::NUM_W'(mag_z);
    num_nxt.ny    = rep_pkg::NUM_W'(mag_y) * rep_pkg::NUM_W'(mag_z);
    num_nxt.dz    = az[rep_pkg::ROT_W-1] ? rep_pkg::ROT_W'(-az) : rep_pkg::ROT_W'(az);
  end

  // stage 4: round half up as floor((2n + d) / 2d), seed the remainders
  always_comb begin
    div_nxt.px    = num_r.px;
    div_nxt.py    = num_r.py;
    div_nxt.hit   = num_r.hit;
    div_nxt.neg_x = num_r.neg_x;
    div_nxt.neg_y = num_r.neg_y;
    div_nxt.mx    = {num_r.nx, 1'b0} + rep_pkg::MW'(num_r.dz);
    div_nxt.my    = {num_r.ny, 1'b0} + rep_pkg::MW'(num_r.dz);
    div_nxt.dd    = {num_r.dz, 1'b0};
    div_nxt.rx    = rep_pkg::RW'(div_nxt.mx >> rep_pkg::QW);
    div_nxt.ry    = rep_pkg::RW'(div_nxt.my >> rep_pkg::QW);
    div_nxt.qx    = '0;
    div_nxt.qy    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_v_r <= 1'b0;
      div_v_r <= 1'b0;
    end else if (en) begin
      num_v_r <= valid_i;
      div_v_r <= num_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      div_r <= div_nxt;
    end
  end

  assign valid_o = div_v_r;
  assign data_o  = div_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rep_div_step.sv =====
`default_nettype none

module rep_div_step #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           valid_i,
  input  rep_pkg::div_t  data_i,
  output logic           valid_o,
  output rep_pkg::div_t  data_o
);

  rep_pkg::div_t step_nxt, step_r;
  logic          step_v_r;

  // one restoring step for both quotients, sharing the divisor
  always_comb begin
    logic [rep_pkg::RW-1:0] tx, ty, dd;
    logic                   ge_x, ge_y;
    dd   = rep_pkg::RW'(data_i.dd);
    tx   = {data_i.rx[rep_pkg::RW-2:0], data_i.mx[BIT]};
    ty   = {data_i.ry[rep_pkg::RW-2:0], data_i.my[BIT]};
    ge_x = tx >= dd;
    ge_y = ty >= dd;
    step_nxt         = data_i;
    step_nxt.rx      = ge_x ? tx - dd : tx;
    step_nxt.ry      = ge_y ? ty - dd : ty;
    step_nxt.qx[BIT] = ge_x;
    step_nxt.qy[BIT] = ge_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_v_r <= 1'b0;
    end else if (en) begin
      step_v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_r <= step_nxt;
    end
  end

  assign valid_o = step_v_r;
  assign data_o  = step_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rep_out.sv =====
`default_nettype none

module rep_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_i,
  input  rep_pkg::div_t  data_i,
  output logic           skid_full,
  output logic           out_valid,
  input  logic           out_stall,
  output rep_pkg::out_t  out_data
);

  function automatic rep_pkg::coord_t sat_cross(
    input rep_pkg::coord_t        p,
    input logic                   neg,
    input logic [rep_pkg::QW-1:0] q
  );
    logic signed [rep_pkg::SW-1:0] off;
    logic signed [rep_pkg::SW-1:0] s;
    logic                          fits;
    rep_pkg::coord_t               res;
    off  = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    s    = rep_pkg::SW'(p) + off;
    // in range when every bit above the sign equals it
    fits = (s[rep_pkg::SW-1:rep_pkg::COORD_BITS-1] == '0)
        || (s[rep_pkg::SW-1:rep_pkg::COORD_BITS-1] == '1);
    if (fits) begin
      res = s[rep_pkg::COORD_BITS-1:0];
    end else if (s[rep_pkg::SW-1]) begin
      res = {1'b1, {(rep_pkg::COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(rep_pkg::COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  rep_pkg::out_t res_nxt;
  rep_pkg::out_t out_data_r, skid_data_r;
  logic          out_valid_r, skid_v_r;
  logic          take, arrive;

  always_comb begin
    res_nxt.hit     = data_i.hit;
    res_nxt.cross_x = '0;
    res_nxt.cross_y = '0;
    if (data_i.hit) begin
      res_nxt.cross_x = sat_cross(data_i.px, data_i.neg_x, data_i.qx);
      res_nxt.cross_y = sat_cross(data_i.py, data_i.neg_y, data_i.qy);
    end
  end

  assign take   = out_valid_r && !out_stall;
  assign arrive = valid_i && !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || take) begin
      out_valid_r <= skid_v_r || arrive;
      skid_v_r    <= 1'b0;
    end else if (arrive) begin
      // output held by the receiver, park the request
      skid_v_r    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      out_data_r <= skid_v_r ? skid_data_r : res_nxt;
    end else if (arrive) begin
      skid_data_r <= res_nxt;
    end
  end

  assign skid_full = skid_v_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled although output was not stalled");

  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> !$past(skid_v_r))
    else $error("output went empty with a request still in the skid");

endmodule

`default_nettype wire

// ===== hw/rtl/rotated_edge_plane_crossing_unit.sv =====
// Edge crossing of the water plane z = 0 under a programmable rotation.
// in channel: in_valid / in_stall carry one vertex position and one body
// frame edge per request; reflect negates both z values first. The edge is
// rotated by the 3x3 Q1.14 matrix and tested against the plane; on a hit
// cross_x / cross_y give the saturated crossing point, otherwise zero.
// out channel: out_valid / out_stall, one result per request, in order.
// cfg channel: cfg_valid / cfg_ready (always ready), cfg_index selects
// matrix row 0..2, other indexes are dropped; write only while idle.
// The pipeline has two rotation stages, two setup stages, one stage per
// quotient bit of the shared-divisor divider (29) and the output register.
// Throughput is one request per cycle while the skid is empty, set by the
// fully pipelined divider. Reset loads the identity matrix and empties the
// pipeline. When out_stall holds a result, the next one is parked in a
// one-entry skid and then the whole pipeline freezes; in_stall is the
// registered skid-full flag, so nothing is lost or repeated.
`default_nettype none

module rotated_edge_plane_crossing_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rep_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rep_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rep_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rep_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [2:0][rep_pkg::ROW_W-1:0] rows_r;
  rep_pkg::mat_t                  mat;
  logic                           en;
  logic                           skid_full;

  logic                           rot_v;
  rep_pkg::rot_t                  rot_d;
  logic                           div_v [rep_pkg::QW+1];
  rep_pkg::div_t                  div_d [rep_pkg::QW+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r[0] <= rep_pkg::ROW0_RST;
      rows_r[1] <= rep_pkg::ROW1_RST;
      rows_r[2] <= rep_pkg::ROW2_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rep_pkg::REG_ROT_ROW0: rows_r[0] <= cfg_data[rep_pkg::ROW_W-1:0];
        rep_pkg::REG_ROT_ROW1: rows_r[1] <= cfg_data[rep_pkg::ROW_W-1:0];
        rep_pkg::REG_ROT_ROW2: rows_r[2] <= cfg_data[rep_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        mat[r][k] = rows_r[r][k*rep_pkg::COEF_BITS +: rep_pkg::COEF_BITS];
      end
    end
  end

  // the whole pipeline moves together unless the skid is holding a result
  assign en       = !skid_full;
  assign in_stall = skid_full;

  rep_rotate u_rotate (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .data_i  (in_data),
    .mat     (mat),
    .valid_o (rot_v),
    .data_o  (rot_d)
  );

  rep_setup u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (rot_v),
    .data_i  (rot_d),
    .valid_o (div_v[0]),
    .data_o  (div_d[0])
  );

  for (genvar i = 0; i < rep_pkg::QW; i++) begin : g_div
    rep_div_step #(
      .BIT (rep_pkg::QW - 1 - i)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (div_v[i]),
      .data_i  (div_d[i]),
      .valid_o (div_v[i+1]),
      .data_o  (div_d[i+1])
    );
  end

  rep_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (div_v[rep_pkg::QW]),
    .data_i    (div_d[rep_pkg::QW]),
    .skid_full (skid_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== bench/rotated_edge_plane_crossing_unit_test.sv =====
`default_nettype none

module rotated_edge_plane_crossing_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  localparam longint SAT_HI   = (longint'(1) << (rep_pkg::COORD_BITS - 1)) - 1;
  localparam longint SAT_LO   = -SAT_HI - 1;
  localparam longint HALF_LSB = longint'(1) << (rep_pkg::FRAC_SHIFT - 1);

  localparam rep_pkg::coord_t C_MAX = 24'sh7FFFFF;
  localparam rep_pkg::coord_t C_MIN = 24'sh800000;

  localparam logic [rep_pkg::COEF_BITS-1:0] K_ONE     = 16'h4000;
  localparam logic [rep_pkg::COEF_BITS-1:0] K_NEG_ONE = 16'hC000;
  localparam logic [rep_pkg::COEF_BITS-1:0] K_MAX     = 16'h7FFF;
  localparam logic [rep_pkg::COEF_BITS-1:0] K_MIN     = 16'h8000;
  localparam logic [rep_pkg::COEF_BITS-1:0] K_ZERO    = 16'h0000;

  // index the block must drop
  localparam logic [rep_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  class crossing_scoreboard;
    logic [rep_pkg::ROW_W-1:0] rows [3];
    rep_pkg::out_t crossings_due [$];
    int errors;
    int checked;
    int requests;
    int hits;

    function new();
      rows[0] = rep_pkg::ROW0_RST;
      rows[1] = rep_pkg::ROW1_RST;
      rows[2] = rep_pkg::ROW2_RST;
      errors = 0;
      checked = 0;
      requests = 0;
      hits = 0;
    endfunction

    function void load_row(logic [rep_pkg::CFG_IDX_W-1:0] idx,
                           logic [rep_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        rep_pkg::REG_ROT_ROW0: rows[0] = value[rep_pkg::ROW_W-1:0];
        rep_pkg::REG_ROT_ROW1: rows[1] = value[rep_pkg::ROW_W-1:0];
        rep_pkg::REG_ROT_ROW2: rows[2] = value[rep_pkg::ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function rep_pkg::coord_t cross_point(longint p, longint a, longint pz, longint az);
      longint na, nz, nd, off, s;
      na = (a < 0) ? -a : a;
      nz = (pz < 0) ? -pz : pz;
      nd = (az < 0) ? -az : az;
      // magnitude rounded half up, sign applied afterwards
      off = (2 * na * nz + nd) / (2 * nd);
      s = (a < 0) ? p - off : p + off;
      if (s > SAT_HI) s = SAT_HI;
      if (s < SAT_LO) s = SAT_LO;
      return rep_pkg::coord_t'(s);
    endfunction

    function rep_pkg::out_t plane_crossing(rep_pkg::in_t req);
      longint e [3];
      longint a [3];
      longint pz, acc, c;
      int row, col;
      rep_pkg::out_t res;
      e[0] = $signed(req.edge_x);
      e[1] = $signed(req.edge_y);
      e[2] = $signed(req.edge_z);
      pz = $signed(req.pos_z);
      if (req.reflect) begin
        pz = -pz;
        e[2] = -e[2];
      end
      for (row = 0; row < 3; row++) begin
        acc = 0;
        for (col = 0; col < 3; col++) begin
          c = $signed(rows[row][col*rep_pkg::COEF_BITS +: rep_pkg::COEF_BITS]);
          acc += c * e[col];
        end
        a[row] = (acc + HALF_LSB) >>> rep_pkg::FRAC_SHIFT;
      end
      res = '0;
      // a vertex on the plane counts as above it
      res.hit = (pz < 0) ? (a[2] + pz > 0) : (a[2] + pz < 0);
      if (res.hit) begin
        res.cross_x = cross_point($signed(req.pos_x), a[0], pz, a[2]);
        res.cross_y = cross_point($signed(req.pos_y), a[1], pz, a[2]);
      end
      return res;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function void note_request(rep_pkg::in_t req);
      rep_pkg::out_t want;
      want = plane_crossing(req);
      requests++;
      if (want.hit) hits++;
      crossings_due = {crossings_due, want};
    endfunction

    task check_result(rep_pkg::out_t got);
      rep_pkg::out_t want;
      if (crossings_due.size() == 0) begin
        report($sformatf("result %b/%h/%h with no request pending",
                         got.hit, got.cross_x, got.cross_y));
        return;
      end
      want = crossings_due.pop_front();
      checked++;
      if (got.hit !== want.hit)
        report($sformatf("result %0d hit %b, want %b", checked, got.hit, want.hit));
      if (got.cross_x !== want.cross_x)
        report($sformatf("result %0d cross_x %h, want %h", checked, got.cross_x,
                         want.cross_x));
      if (got.cross_y !== want.cross_y)
        report($sformatf("result %0d cross_y %h, want %h", checked, got.cross_y,
                         want.cross_y));
    endtask

    task finish_check();
      if (crossings_due.size() != 0)
        report($sformatf("%0d results never arrived", crossings_due.size()));
    endtask
  endclass

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  rep_pkg::in_t  in_data;
  logic   out_valid;
  logic   out_stall;
  rep_pkg::out_t out_data;
  logic   cfg_valid;
  logic   cfg_ready;
  logic [rep_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rep_pkg::CFG_DATA_W-1:0] cfg_data;

  crossing_scoreboard board = new();
  rep_pkg::in_t batch [$];
  bit  steady;
  int  holds_asked = 0;
  int  settings_used = 1;

  rotated_edge_plane_crossing_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic rep_pkg::in_t request_of(rep_pkg::coord_t px, rep_pkg::coord_t py,
                                              rep_pkg::coord_t pz, rep_pkg::coord_t ex,
                                              rep_pkg::coord_t ey, rep_pkg::coord_t ez,
                                              logic refl);
    rep_pkg::in_t r;
    r.pos_x = px;
    r.pos_y = py;
    r.pos_z = pz;
    r.edge_x = ex;
    r.edge_y = ey;
    r.edge_z = ez;
    r.reflect = refl;
    return r;
  endfunction

  function automatic void queue_request(rep_pkg::in_t r);
    batch = {batch, r};
  endfunction

  function automatic logic [rep_pkg::ROW_W-1:0] row_of(logic [rep_pkg::COEF_BITS-1:0] c0,
                                                        logic [rep_pkg::COEF_BITS-1:0] c1,
                                                        logic [rep_pkg::COEF_BITS-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic logic [rep_pkg::COEF_BITS-1:0] random_coef(bit mild);
    logic signed [rep_pkg::COEF_BITS-1:0] v;
    v = rep_pkg::COEF_BITS'($urandom);
    return mild ? v >>> 6 : v;
  endfunction

  // full-width draws now and then, mostly scaled down
  function automatic rep_pkg::coord_t wide_coord();
    logic signed [rep_pkg::COORD_BITS-1:0] v;
    v = rep_pkg::COORD_BITS'($urandom);
    return v >>> $urandom_range(0, rep_pkg::COORD_BITS - 1);
  endfunction

  function automatic rep_pkg::coord_t corner_coord();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return 24'sd1;
      default: return -24'sd1;
    endcase
  endfunction

  function automatic rep_pkg::in_t random_request();
    rep_pkg::in_t r;
    longint depth, reach, pz, ez;
    int pick;
    r.pos_x = wide_coord();
    r.pos_y = wide_coord();
    r.edge_x = wide_coord();
    r.edge_y = wide_coord();
    r.reflect = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      // vertex on one side, edge reaching past the plane in body frame
      depth = $urandom_range(0, 22'h3FFFFF) >> $urandom_range(0, 21);
      reach = depth + 1 + ($urandom_range(0, 22'h3FFFFF) >> $urandom_range(0, 21));
      pz = $urandom_range(0, 1) ? -depth : depth;
      ez = (pz < 0) ? reach : -reach;
      if (r.reflect) begin
        pz = -pz;
        ez = -ez;
      end
      r.pos_z = rep_pkg::coord_t'(pz);
      r.edge_z = rep_pkg::coord_t'(ez);
    end else if (pick < 9) begin
      r.pos_z = wide_coord();
      r.edge_z = wide_coord();
    end else begin
      r = request_of(corner_coord(), corner_coord(), corner_coord(), corner_coord(),
                     corner_coord(), corner_coord(), r.reflect);
    end
    return r;
  endfunction

  task automatic send_batch();
    int burst_left;
    int i;
    burst_left = $urandom_range(1, 24);
    for (i = 0; i < batch.size(); i++) begin
      in_valid <= 1'b1;
      in_data <= batch[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      board.note_request(batch[i]);
      if (!steady && i + 1 < batch.size()) begin
        burst_left--;
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 40)) @(posedge clk);
          burst_left = $urandom_range(1, 24);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (board.crossings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count, input bit gapless);
    batch.delete();
    repeat (count) queue_request(random_request());
    steady = gapless;
    send_batch();
    settle();
  endtask

  task automatic cfg_write(input logic [rep_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rep_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.load_row(idx, value);
  endtask

  task automatic program_matrix(input logic [rep_pkg::ROW_W-1:0] r0,
                                input logic [rep_pkg::ROW_W-1:0] r1,
                                input logic [rep_pkg::ROW_W-1:0] r2);
    cfg_write(REG_UNUSED, rep_pkg::CFG_DATA_W'({$urandom, $urandom}));
    cfg_write(rep_pkg::REG_ROT_ROW0, r0);
    cfg_write(rep_pkg::REG_ROT_ROW1, r1);
    cfg_write(rep_pkg::REG_ROT_ROW2, r2);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // result side: checks every accepted result and stalls on its own pattern
  initial begin : result_side
    int hold_left;
    int holds_done;
    int cycle;
    hold_left = 0;
    holds_done = 0;
    cycle = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_data);
      cycle++;
      if (hold_left == 0 && holds_done < holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((cycle / 97) % 4)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ((cycle % 5) < 2);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("rotated_edge_plane_crossing_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset matrix is the identity, so rotated edge equals body edge
    batch.delete();
    queue_request(request_of(24'sd4096, -24'sd8192, -24'sd4096, 24'sd2048, 24'sd1024,
                             24'sd8192, 1'b0));
    queue_request(request_of(24'sd0, 24'sd0, 24'sd4096, 24'sd4096, -24'sd4096,
                             -24'sd8192, 1'b0));
    // vertex on the plane: hit only when heading down, crossing is the vertex
    queue_request(request_of(24'sd1234, -24'sd5678, 24'sd0, 24'sd100, 24'sd200,
                             -24'sd1, 1'b0));
    queue_request(request_of(24'sd1234, -24'sd5678, 24'sd0, 24'sd100, 24'sd200,
                             24'sd1, 1'b0));
    queue_request(request_of(24'sd7, 24'sd7, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0));
    // ending exactly on the plane is not a crossing
    queue_request(request_of(24'sd0, 24'sd0, -24'sd4096, 24'sd5, 24'sd5, 24'sd4096, 1'b0));
    queue_request(request_of(24'sd0, 24'sd0, 24'sd4096, 24'sd5, 24'sd5, -24'sd4096, 1'b0));
    queue_request(request_of(24'sd0, 24'sd0, -24'sd4096, 24'sd5, 24'sd5, 24'sd4097, 1'b0));
    // saturation both ways
    queue_request(request_of(C_MAX, C_MAX, -24'sd1, C_MAX, C_MAX, 24'sd2, 1'b0));
    queue_request(request_of(C_MIN, C_MIN, -24'sd1, C_MIN, C_MIN, 24'sd2, 1'b0));
    // rounding of halves away from zero
    queue_request(request_of(24'sd0, 24'sd0, -24'sd1, 24'sd1, -24'sd1, 24'sd2, 1'b0));
    queue_request(request_of(24'sd0, 24'sd0, -24'sd1, 24'sd3, -24'sd3, 24'sd2, 1'b0));
    // reflection of the most negative z goes to full width
    queue_request(request_of(24'sd0, 24'sd0, C_MIN, C_MAX, C_MIN, C_MAX, 1'b1));
    queue_request(request_of(24'sd0, 24'sd0, C_MAX, 24'sd3, 24'sd3, C_MIN, 1'b1));
    queue_request(request_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b0));
    queue_request(request_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
    queue_request(request_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1));
    queue_request(request_of('0, '0, '0, '0, '0, '0, 1'b0));
    queue_request(request_of(-24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, -24'sd1, 1'b1));
    queue_request(request_of(24'sd100, -24'sd100, 24'sd1, C_MAX, C_MIN, C_MIN, 1'b0));
    queue_request(request_of(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, 1'b0));
    queue_request(request_of(C_MAX, C_MIN, -24'sd1, C_MIN, C_MAX, C_MAX, 1'b0));
    steady = 1'b0;
    send_batch();
    settle();

    random_phase(60, 1'b1);

    program_matrix(row_of(K_MAX, K_MAX, K_MAX), row_of(K_MAX, K_MAX, K_MAX),
                   row_of(K_MAX, K_MAX, K_MAX));
    holds_asked <= holds_asked + 1;
    random_phase(70, 1'b0);

    program_matrix(row_of(K_MIN, K_MIN, K_MIN), row_of(K_MIN, K_MIN, K_MIN),
                   row_of(K_MIN, K_MIN, K_MIN));
    random_phase(70, 1'b0);

    // quarter turn about z with z flipped
    program_matrix(row_of(K_ZERO, K_ONE, K_ZERO), row_of(K_NEG_ONE, K_ZERO, K_ZERO),
                   row_of(K_ZERO, K_ZERO, K_NEG_ONE));
    random_phase(70, 1'b0);

    program_matrix(row_of(random_coef(0), random_coef(0), random_coef(0)),
                   row_of(random_coef(0), random_coef(0), random_coef(0)),
                   row_of(random_coef(0), random_coef(0), random_coef(0)));
    random_phase(70, 1'b0);

    // slight tilt keeps most crossings alive
    program_matrix(row_of(random_coef(0), random_coef(0), random_coef(0)),
                   row_of(random_coef(0), random_coef(0), random_coef(0)),
                   row_of(random_coef(1), random_coef(1), K_ONE));
    holds_asked <= holds_asked + 1;
    random_phase(70, 1'b0);

    program_matrix(row_of(K_ZERO, K_ZERO, K_ZERO), row_of(K_ZERO, K_ZERO, K_ZERO),
                   row_of(K_ZERO, K_ZERO, K_ZERO));
    random_phase(40, 1'b0);

    program_matrix(rep_pkg::ROW0_RST, rep_pkg::ROW1_RST, rep_pkg::ROW2_RST);
    random_phase(80, 1'b1);

    board.finish_check();
    $display("checked %0d of %0d requests, %0d of them crossings, under %0d matrices",
             board.checked, board.requests, board.hits, settings_used);
    $display("input bursts, output stall patterns and %0d long output holds", holds_asked);
    if (board.errors == 0) begin
      $display("rotated_edge_plane_crossing_unit regression: pass");
    end else begin
      $display("rotated_edge_plane_crossing_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
